/* src/vna_pkg.sv */
// shared types, constants and the command/status structs for the normal accumulator
package vna_pkg;

    localparam int VERTEX_SLOTS_DEF = 1024;
    localparam int COORD_BITS_DEF   = 16;
    localparam int SUM_BITS_DEF     = 24;

    localparam int IDX_W   = 10;
    localparam int FIELD_W = 16;
    localparam int Q14_W   = 16;
    localparam int MAG_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int QUO_W   = 15;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_TRI  = 2'd1,
        MODE_READ = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RDA,
        ST_RDB,
        ST_RDC,
        ST_EDGE,
        ST_MUL,
        ST_CROSS,
        ST_NORM,
        ST_ACC_A,
        ST_WR_A,
        ST_ACC_B,
        ST_WR_B,
        ST_ACC_C,
        ST_WR_C,
        ST_RDS,
        ST_SUMV,
        ST_NORM_RD,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_CAPTURE,
        CMD_LOAD,
        CMD_RD_POS_A,
        CMD_RD_POS_B,
        CMD_RD_POS_C,
        CMD_EDGE,
        CMD_MUL,
        CMD_CROSS,
        CMD_ACC_RD,
        CMD_ACC_WR,
        CMD_RD_SUM,
        CMD_SUM_VEC,
        CMD_OUT
    } t_dp_op;

    typedef enum logic [1:0] {
        CORNER_A = 2'd0,
        CORNER_B = 2'd1,
        CORNER_C = 2'd2
    } t_corner;

    typedef struct packed {
        t_dp_op  op;
        t_corner corner;
        logic    norm_start;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  idx_ok;
        logic  tri_ok;
        logic  norm_done;
        logic  norm_zero;
        logic  out_taken;
    } t_dp_status;

endpackage

/* src/vna_unit_norm.sv */
// multi-cycle unit-length scaler: shift, bit-serial square root, restoring divides
module vna_unit_norm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [vna_pkg::MAG_W-1:0]  i_vx,
    input  logic signed [vna_pkg::MAG_W-1:0]  i_vy,
    input  logic signed [vna_pkg::MAG_W-1:0]  i_vz,
    output logic                              o_done,
    output logic                              o_zero,
    output logic signed [vna_pkg::Q14_W-1:0]  o_nx,
    output logic signed [vna_pkg::Q14_W-1:0]  o_ny,
    output logic signed [vna_pkg::Q14_W-1:0]  o_nz
);

    localparam int MW = vna_pkg::MAG_W;
    localparam int SH = 31;
    localparam int RW = vna_pkg::ROOT_W;
    localparam int QW = vna_pkg::QUO_W;
    localparam int NW = 45;
    localparam int PW = 7;

    typedef enum logic [2:0] {
        U_IDLE, U_PRI, U_SHIFT, U_SQ, U_SQRT, U_DIV, U_DONE
    } t_ust;

    t_ust r_st, n_st;

    logic [MW-1:0] r_m [3];
    logic [MW-1:0] n_m [3];
    logic [2:0]    r_sg;
    logic [MW-1:0] r_s;
    logic [MW-1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [PW-1:0] r_cnt;
    logic [1:0]    r_lane;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_drem;
    logic [QW-1:0] r_q;
    logic [QW-1:0] r_qo [3];
    logic          r_zero;
    logic [MW-1:0] mx;
    logic [PW-1:0] msb;
    logic [MW+1:0] trial;
    logic [NW:0]   dtrial;
    logic [29:0]   sq_op;
    logic [59:0]   sq;

    always_comb begin
        mx = r_m[0];
        if (r_m[1] > mx) mx = r_m[1];
        if (r_m[2] > mx) mx = r_m[2];
        msb = '0;
        for (int i = 0; i < MW; i++) begin
            if (mx[i]) msb = PW'(i);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (msb > PW'(29)) n_m[i] = r_m[i] >> (msb - PW'(29));
            else n_m[i] = r_m[i] << (PW'(29) - msb);
        end
    end

    // shifted magnitudes stay below 2^30
    assign sq_op = r_m[r_lane][29:0];
    assign sq = sq_op * sq_op;
    assign trial = {r_rem, r_s[MW-1 -: 2]} - {r_root, 2'b01};
    assign dtrial = {r_drem, r_num[NW-1]} - {{(NW+1-RW){1'b0}}, r_root};

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            U_IDLE:  if (i_start) n_st = U_PRI;
            U_PRI:   n_st = (mx == '0) ? U_DONE : U_SHIFT;
            U_SHIFT: n_st = U_SQ;
            U_SQ:    if (r_lane == 2'd2) n_st = U_SQRT;
            U_SQRT:  if (r_cnt == PW'(SH + 1)) n_st = U_DIV;
            U_DIV:   if (r_lane == 2'd2 && r_cnt == PW'(NW - 1)) n_st = U_DONE;
            U_DONE:  n_st = U_IDLE;
            default: n_st = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= U_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            U_IDLE: begin
                if (i_start) begin
                    r_m[0] <= i_vx[MW-1] ? MW'(-i_vx) : MW'(i_vx);
                    r_m[1] <= i_vy[MW-1] ? MW'(-i_vy) : MW'(i_vy);
                    r_m[2] <= i_vz[MW-1] ? MW'(-i_vz) : MW'(i_vz);
                    r_sg   <= {i_vz[MW-1], i_vy[MW-1], i_vx[MW-1]};
                end
            end
            U_PRI: begin
                r_zero <= (mx == '0);
            end
            U_SHIFT: begin
                for (int i = 0; i < 3; i++) r_m[i] <= n_m[i];
                r_s    <= '0;
                r_lane <= 2'd0;
            end
            U_SQ: begin
                r_s    <= r_s + MW'(sq);
                r_lane <= r_lane + 2'd1;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            U_SQRT: begin
                // one result bit per cycle, two radicand bits consumed
                if (r_cnt <= PW'(SH)) begin
                    r_s <= r_s << 2;
                    if (!trial[MW+1]) begin
                        r_rem  <= trial[MW-1:0];
                        r_root <= {r_root[RW-2:0], 1'b1};
                    end else begin
                        r_rem  <= {r_rem[MW-3:0], r_s[MW-1 -: 2]};
                        r_root <= {r_root[RW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + PW'(1);
                end else begin
                    r_lane <= 2'd0;
                    r_cnt  <= '0;
                    r_num  <= NW'(r_m[0] << 14) + NW'(r_root >> 1);
                    r_drem <= '0;
                    r_q    <= '0;
                end
            end
            U_DIV: begin
                if (!dtrial[NW]) begin
                    r_drem <= dtrial[NW-1:0];
                    r_q    <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_drem <= {r_drem[NW-2:0], r_num[NW-1]};
                    r_q    <= {r_q[QW-2:0], 1'b0};
                end
                r_num <= r_num << 1;
                if (r_cnt == PW'(NW - 1)) begin
                    r_qo[r_lane] <= dtrial[NW] ? {r_q[QW-2:0], 1'b0} : {r_q[QW-2:0], 1'b1};
                    r_lane <= r_lane + 2'd1;
                    r_cnt  <= '0;
                    r_drem <= '0;
                    r_q    <= '0;
                    r_num  <= NW'(r_m[2'(r_lane + 2'd1)] << 14) + NW'(r_root >> 1);
                end else begin
                    r_cnt <= r_cnt + PW'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_done = (r_st == U_DONE);
    assign o_zero = r_zero;
    assign o_nx = r_zero ? '0 : (r_sg[0] ? -$signed({1'b0, r_qo[0]}) : $signed({1'b0, r_qo[0]}));
    assign o_ny = r_zero ? '0 : (r_sg[1] ? -$signed({1'b0, r_qo[1]}) : $signed({1'b0, r_qo[1]}));
    assign o_nz = r_zero ? '0 : (r_sg[2] ? -$signed({1'b0, r_qo[2]}) : $signed({1'b0, r_qo[2]}));

endmodule

/* src/vna_datapath.sv */
// datapath: vertex memories, edge and cross product, saturating accumulate, result register
module vna_datapath #(
    parameter int VERTEX_SLOTS = vna_pkg::VERTEX_SLOTS_DEF,
    parameter int COORD_BITS   = vna_pkg::COORD_BITS_DEF,
    parameter int SUM_BITS     = vna_pkg::SUM_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vna_pkg::t_dp_cmd                    i_cmd,
    output vna_pkg::t_dp_status                 o_status,
    input  logic [1:0]                          i_mode,
    input  logic [vna_pkg::IDX_W-1:0]           i_vertex_index,
    input  logic signed [vna_pkg::FIELD_W-1:0]  i_pos_x,
    input  logic signed [vna_pkg::FIELD_W-1:0]  i_pos_y,
    input  logic signed [vna_pkg::FIELD_W-1:0]  i_pos_z,
    input  logic [vna_pkg::IDX_W-1:0]           i_tri_first,
    input  logic [vna_pkg::IDX_W-1:0]           i_tri_second,
    input  logic [vna_pkg::IDX_W-1:0]           i_tri_third,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [vna_pkg::IDX_W-1:0]           o_read_index,
    output logic signed [vna_pkg::Q14_W-1:0]    o_normal_x,
    output logic signed [vna_pkg::Q14_W-1:0]    o_normal_y,
    output logic signed [vna_pkg::Q14_W-1:0]    o_normal_z,
    output logic                                o_zero_normal
);

    localparam int AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
    localparam int CB = COORD_BITS;
    localparam int EB = CB + 1;
    localparam int PB = 2 * EB;
    localparam int XB = PB + 1;
    localparam int MW = vna_pkg::MAG_W;
    localparam int IW = vna_pkg::IDX_W;
    localparam int QW = vna_pkg::Q14_W;
    localparam logic signed [SUM_BITS:0] SMAX = (SUM_BITS+1)'((64'sd1 <<< (SUM_BITS-1)) - 1);
    localparam logic signed [SUM_BITS:0] SMIN = -SMAX - (SUM_BITS+1)'(1);

    logic signed [3*CB-1:0]       pos_mem [VERTEX_SLOTS];
    logic signed [3*SUM_BITS-1:0] sum_mem [VERTEX_SLOTS];

    logic [1:0]  r_mode;
    logic [IW-1:0] r_vi, r_ta, r_tb, r_tc;
    logic signed [CB-1:0] r_px, r_py, r_pz;
    logic signed [3*CB-1:0] r_pos_q, r_pa;
    logic signed [3*SUM_BITS-1:0] r_sum_q;
    logic signed [EB-1:0] r_e1 [3];
    logic signed [EB-1:0] r_e2 [3];
    logic signed [PB-1:0] r_pr [6];
    logic signed [MW-1:0] r_v [3];
    logic        r_valid;
    logic [IW-1:0] r_oi;
    logic signed [QW-1:0] r_ox, r_oy, r_oz;
    logic        r_oz_f;

    logic [IW-1:0] corner_idx;
    logic [AW-1:0] addr;
    logic signed [CB-1:0] pb [3];
    logic signed [CB-1:0] pa [3];
    logic signed [SUM_BITS-1:0] sm [3];
    logic signed [SUM_BITS-1:0] sa [3];
    logic signed [QW-1:0] nn [3];
    logic signed [SUM_BITS:0] tsum;
    logic u_done, u_zero;
    logic signed [QW-1:0] u_nx, u_ny, u_nz;

    function automatic logic in_range(input logic [IW-1:0] v);
        return ({1'b0, v} < (IW+1)'(VERTEX_SLOTS)) || (VERTEX_SLOTS > (1 << IW));
    endfunction

    always_comb begin
        case (i_cmd.corner)
            vna_pkg::CORNER_A: corner_idx = r_ta;
            vna_pkg::CORNER_B: corner_idx = r_tb;
            default:           corner_idx = r_tc;
        endcase
        if (i_cmd.op == vna_pkg::CMD_RD_SUM || i_cmd.op == vna_pkg::CMD_LOAD) begin
            addr = AW'(r_vi);
        end else begin
            addr = AW'(corner_idx);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pb[i] = r_pos_q[i*CB +: CB];
            pa[i] = r_pa[i*CB +: CB];
            sm[i] = r_sum_q[i*SUM_BITS +: SUM_BITS];
        end
        nn[0] = u_nx;
        nn[1] = u_ny;
        nn[2] = u_nz;
        tsum = '0;
        for (int i = 0; i < 3; i++) begin
            tsum = (SUM_BITS+1)'(sm[i]) + (SUM_BITS+1)'(nn[i]);
            if (tsum > SMAX) sa[i] = SMAX[SUM_BITS-1:0];
            else if (tsum < SMIN) sa[i] = SMIN[SUM_BITS-1:0];
            else sa[i] = tsum[SUM_BITS-1:0];
        end
    end

    // memory ports: one read and one write per cycle each
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == vna_pkg::CMD_LOAD) begin
            pos_mem[addr] <= {r_pz, r_py, r_px};
        end
        r_pos_q <= pos_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == vna_pkg::CMD_LOAD) begin
            sum_mem[addr] <= '0;
        end else if (i_cmd.op == vna_pkg::CMD_ACC_WR) begin
            sum_mem[addr] <= {sa[2], sa[1], sa[0]};
        end
        r_sum_q <= sum_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            vna_pkg::CMD_CAPTURE: begin
                r_mode <= i_mode;
                r_vi <= i_vertex_index;
                r_px <= CB'(i_pos_x);
                r_py <= CB'(i_pos_y);
                r_pz <= CB'(i_pos_z);
                r_ta <= i_tri_first;
                r_tb <= i_tri_second;
                r_tc <= i_tri_third;
            end
            vna_pkg::CMD_RD_POS_B: r_pa <= r_pos_q;
            vna_pkg::CMD_RD_POS_C: begin
                for (int i = 0; i < 3; i++) r_e1[i] <= EB'(pb[i]) - EB'(pa[i]);
            end
            vna_pkg::CMD_EDGE: begin
                for (int i = 0; i < 3; i++) r_e2[i] <= EB'(pb[i]) - EB'(pa[i]);
            end
            vna_pkg::CMD_MUL: begin
                r_pr[0] <= r_e1[1] * r_e2[2];
                r_pr[1] <= r_e1[2] * r_e2[1];
                r_pr[2] <= r_e1[2] * r_e2[0];
                r_pr[3] <= r_e1[0] * r_e2[2];
                r_pr[4] <= r_e1[0] * r_e2[1];
                r_pr[5] <= r_e1[1] * r_e2[0];
            end
            vna_pkg::CMD_CROSS: begin
                r_v[0] <= MW'(XB'(r_pr[0]) - XB'(r_pr[1]));
                r_v[1] <= MW'(XB'(r_pr[2]) - XB'(r_pr[3]));
                r_v[2] <= MW'(XB'(r_pr[4]) - XB'(r_pr[5]));
            end
            vna_pkg::CMD_SUM_VEC: begin
                for (int i = 0; i < 3; i++) r_v[i] <= MW'(sm[i]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.op == vna_pkg::CMD_OUT) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == vna_pkg::CMD_OUT) begin
            r_oi <= r_vi;
            if (in_range(r_vi)) begin
                r_ox <= u_nx;
                r_oy <= u_ny;
                r_oz <= u_nz;
                r_oz_f <= u_zero;
            end else begin
                r_ox <= '0;
                r_oy <= '0;
                r_oz <= '0;
                r_oz_f <= 1'b1;
            end
        end
    end

    vna_unit_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.norm_start),
        .i_vx    (r_v[0]),
        .i_vy    (r_v[1]),
        .i_vz    (r_v[2]),
        .o_done  (u_done),
        .o_zero  (u_zero),
        .o_nx    (u_nx),
        .o_ny    (u_ny),
        .o_nz    (u_nz)
    );

    assign o_status.mode      = vna_pkg::t_mode'(r_mode);
    assign o_status.idx_ok    = in_range(r_vi);
    assign o_status.tri_ok    = in_range(r_ta) && in_range(r_tb) && in_range(r_tc);
    assign o_status.norm_done = u_done;
    assign o_status.norm_zero = u_zero;
    assign o_status.out_taken = !r_valid || !i_stall;

    assign o_valid       = r_valid;
    assign o_read_index  = r_oi;
    assign o_normal_x    = r_ox;
    assign o_normal_y    = r_oy;
    assign o_normal_z    = r_oz;
    assign o_zero_normal = r_oz_f;

endmodule

/* src/vna_ctrl.sv */
// controller state machine sequencing the datapath per request
module vna_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  vna_pkg::t_dp_status i_status,
    output vna_pkg::t_dp_cmd    o_cmd
);

    vna_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vna_pkg::ST_IDLE: if (i_valid) n_state = vna_pkg::ST_LOAD;
            vna_pkg::ST_LOAD: begin
                unique case (i_status.mode)
                    vna_pkg::MODE_LOAD: n_state = vna_pkg::ST_IDLE;
                    vna_pkg::MODE_TRI:
                        n_state = i_status.tri_ok ? vna_pkg::ST_RDA : vna_pkg::ST_IDLE;
                    vna_pkg::MODE_READ: n_state = vna_pkg::ST_RDS;
                    default: n_state = vna_pkg::ST_IDLE;
                endcase
            end
            vna_pkg::ST_RDA:   n_state = vna_pkg::ST_RDB;
            vna_pkg::ST_RDB:   n_state = vna_pkg::ST_RDC;
            vna_pkg::ST_RDC:   n_state = vna_pkg::ST_EDGE;
            vna_pkg::ST_EDGE:  n_state = vna_pkg::ST_MUL;
            vna_pkg::ST_MUL:   n_state = vna_pkg::ST_CROSS;
            vna_pkg::ST_CROSS: n_state = vna_pkg::ST_NORM;
            vna_pkg::ST_NORM: begin
                if (i_status.norm_done)
                    n_state = i_status.norm_zero ? vna_pkg::ST_IDLE : vna_pkg::ST_ACC_A;
            end
            vna_pkg::ST_ACC_A: n_state = vna_pkg::ST_WR_A;
            vna_pkg::ST_WR_A:  n_state = vna_pkg::ST_ACC_B;
            vna_pkg::ST_ACC_B: n_state = vna_pkg::ST_WR_B;
            vna_pkg::ST_WR_B:  n_state = vna_pkg::ST_ACC_C;
            vna_pkg::ST_ACC_C: n_state = vna_pkg::ST_WR_C;
            vna_pkg::ST_WR_C:  n_state = vna_pkg::ST_IDLE;
            vna_pkg::ST_RDS:   n_state = vna_pkg::ST_SUMV;
            vna_pkg::ST_SUMV:  n_state = vna_pkg::ST_NORM_RD;
            vna_pkg::ST_NORM_RD: if (i_status.norm_done) n_state = vna_pkg::ST_OUT;
            vna_pkg::ST_OUT:   if (i_status.out_taken) n_state = vna_pkg::ST_IDLE;
            default: n_state = vna_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = vna_pkg::CMD_NOP;
        o_cmd.corner = vna_pkg::CORNER_A;
        o_cmd.norm_start = 1'b0;
        o_stall = 1'b1;
        unique case (r_state)
            vna_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                o_cmd.op = vna_pkg::CMD_CAPTURE;
            end
            vna_pkg::ST_LOAD: begin
                if (i_status.mode == vna_pkg::MODE_LOAD && i_status.idx_ok)
                    o_cmd.op = vna_pkg::CMD_LOAD;
            end
            vna_pkg::ST_RDA: o_cmd.op = vna_pkg::CMD_RD_POS_A;
            vna_pkg::ST_RDB: begin
                o_cmd.op = vna_pkg::CMD_RD_POS_B;
                o_cmd.corner = vna_pkg::CORNER_B;
            end
            vna_pkg::ST_RDC: begin
                o_cmd.op = vna_pkg::CMD_RD_POS_C;
                o_cmd.corner = vna_pkg::CORNER_C;
            end
            vna_pkg::ST_EDGE:  o_cmd.op = vna_pkg::CMD_EDGE;
            vna_pkg::ST_MUL:   o_cmd.op = vna_pkg::CMD_MUL;
            vna_pkg::ST_CROSS: o_cmd.op = vna_pkg::CMD_CROSS;
            vna_pkg::ST_NORM: begin
                o_cmd.norm_start = 1'b1;
                o_cmd.op = vna_pkg::CMD_ACC_RD;
            end
            vna_pkg::ST_ACC_A: o_cmd.op = vna_pkg::CMD_ACC_RD;
            vna_pkg::ST_WR_A:  o_cmd.op = vna_pkg::CMD_ACC_WR;
            vna_pkg::ST_ACC_B: begin
                o_cmd.op = vna_pkg::CMD_ACC_RD;
                o_cmd.corner = vna_pkg::CORNER_B;
            end
            vna_pkg::ST_WR_B: begin
                o_cmd.op = vna_pkg::CMD_ACC_WR;
                o_cmd.corner = vna_pkg::CORNER_B;
            end
            vna_pkg::ST_ACC_C: begin
                o_cmd.op = vna_pkg::CMD_ACC_RD;
                o_cmd.corner = vna_pkg::CORNER_C;
            end
            vna_pkg::ST_WR_C: begin
                o_cmd.op = vna_pkg::CMD_ACC_WR;
                o_cmd.corner = vna_pkg::CORNER_C;
            end
            vna_pkg::ST_RDS:  o_cmd.op = vna_pkg::CMD_RD_SUM;
            vna_pkg::ST_SUMV: o_cmd.op = vna_pkg::CMD_SUM_VEC;
            vna_pkg::ST_NORM_RD: o_cmd.norm_start = 1'b1;
            vna_pkg::ST_OUT: if (i_status.out_taken) o_cmd.op = vna_pkg::CMD_OUT;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vna_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/vertex_normal_accumulator.sv */
// top level: smooth vertex normal accumulator
// one request at a time: a load writes one vertex, a triangle is read, crossed, normalised and
// accumulated (the normaliser runs setup, square root, three divides, done), a read waits on stalls
// a zero-area triangle is not accumulated and a zero vector skips root and divides; the normaliser sets the rate
// result leaves through an output register, taken when i_stall is low
// synchronous active-low reset clears control only; vertex memories are not cleared
module vertex_normal_accumulator #(
    parameter int VERTEX_SLOTS = vna_pkg::VERTEX_SLOTS_DEF,
    parameter int COORD_BITS   = vna_pkg::COORD_BITS_DEF,
    parameter int SUM_BITS     = vna_pkg::SUM_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_mode,
    input  logic [vna_pkg::IDX_W-1:0]           i_vertex_index,
    input  logic signed [vna_pkg::FIELD_W-1:0]  i_pos_x,
    input  logic signed [vna_pkg::FIELD_W-1:0]  i_pos_y,
    input  logic signed [vna_pkg::FIELD_W-1:0]  i_pos_z,
    input  logic [vna_pkg::IDX_W-1:0]           i_tri_first,
    input  logic [vna_pkg::IDX_W-1:0]           i_tri_second,
    input  logic [vna_pkg::IDX_W-1:0]           i_tri_third,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [vna_pkg::IDX_W-1:0]           o_read_index,
    output logic signed [vna_pkg::Q14_W-1:0]    o_normal_x,
    output logic signed [vna_pkg::Q14_W-1:0]    o_normal_y,
    output logic signed [vna_pkg::Q14_W-1:0]    o_normal_z,
    output logic                                o_zero_normal
);

    vna_pkg::t_dp_cmd    cmd;
    vna_pkg::t_dp_status status;

    vna_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    vna_datapath #(
        .VERTEX_SLOTS (VERTEX_SLOTS),
        .COORD_BITS   (COORD_BITS),
        .SUM_BITS     (SUM_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_mode         (i_mode),
        .i_vertex_index (i_vertex_index),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_tri_first    (i_tri_first),
        .i_tri_second   (i_tri_second),
        .i_tri_third    (i_tri_third),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_index   (o_read_index),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z),
        .o_zero_normal  (o_zero_normal)
    );

endmodule
